/* hw/rtl/hpc_pkg.sv */
`timescale 1ns / 1ps

package hpc_pkg;

    // field widths
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;
    localparam int DATA_W  = 16;
    localparam int ANGLE_W = 17;
    localparam int INTEG_W = 32;
    localparam int CFG_IDX_W = 4;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LOW_ANGLE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_HIGH_ANGLE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_ZONE      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND       = 4'd7;

    // reset values, degrees times 256
    localparam logic [LIM_W-1:0] RST_MIN_ANGLE       = 15'd4096;
    localparam logic [LIM_W-1:0] RST_MAX_ANGLE       = 15'd23040;
    localparam logic [LIM_W-1:0] RST_SLOW_LOW_ANGLE  = 15'd6400;
    localparam logic [LIM_W-1:0] RST_SLOW_HIGH_ANGLE = 15'd20736;
    localparam logic [LIM_W-1:0] RST_INTEG_ZONE      = 15'd1280;
    localparam logic [LIM_W-1:0] RST_DEAD_BAND       = 15'd77;

    // 101 degrees times 256
    localparam logic signed [ANGLE_W-1:0] ANGLE_OFFSET = 17'sd25856;
    // integrator gain per tick, 1 / 0.02
    localparam logic signed [22:0] INTEG_RATE = 23'sd50;
    // x / 5 as (x * 52429) >> 18, exact for x up to 65536
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int DIV5_SHIFT = 18;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [LIM_W-1:0]  min_angle;
        logic [LIM_W-1:0]  max_angle;
        logic [LIM_W-1:0]  slow_low_angle;
        logic [LIM_W-1:0]  slow_high_angle;
        logic [LIM_W-1:0]  integ_zone;
        logic [LIM_W-1:0]  dead_band;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     on_target;
        logic                     limited;
    } t_drive_res;

endpackage

/* hw/rtl/hpc_cfg_if.sv */
`timescale 1ns / 1ps

interface hpc_cfg_if;
    import hpc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/hpc_in_if.sv */
`timescale 1ns / 1ps

interface hpc_in_if;
    import hpc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [DATA_W-1:0] encoder_reading;
    logic signed [DATA_W-1:0] target_angle;
    logic signed [DATA_W-1:0] manual_drive;

    modport source (output valid, output operation, output encoder_reading,
                    output target_angle, output manual_drive, input ready);
    modport sink   (input valid, input operation, input encoder_reading,
                    input target_angle, input manual_drive, output ready);
endinterface

/* hw/rtl/hpc_out_if.sv */
`timescale 1ns / 1ps

interface hpc_out_if;
    import hpc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_command;
    logic                     on_target;
    logic                     limited;

    modport source (output valid, output drive_command, output on_target,
                    output limited, input ready);
    modport sink   (input valid, input drive_command, input on_target,
                    input limited, output ready);
endinterface

/* hw/rtl/hpc_cfg_regs.sv */
`timescale 1ns / 1ps

module hpc_cfg_regs
    import hpc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    hpc_cfg_if.sink i_cfg,
    output t_cfg   o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= '0;
            r_cfg.integ_gain      <= '0;
            r_cfg.min_angle       <= RST_MIN_ANGLE;
            r_cfg.max_angle       <= RST_MAX_ANGLE;
            r_cfg.slow_low_angle  <= RST_SLOW_LOW_ANGLE;
            r_cfg.slow_high_angle <= RST_SLOW_HIGH_ANGLE;
            r_cfg.integ_zone      <= RST_INTEG_ZONE;
            r_cfg.dead_band       <= RST_DEAD_BAND;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PROP_GAIN:       r_cfg.prop_gain       <= i_cfg.data;
                REG_INTEG_GAIN:      r_cfg.integ_gain      <= i_cfg.data;
                REG_MIN_ANGLE:       r_cfg.min_angle       <= i_cfg.data[LIM_W-1:0];
                REG_MAX_ANGLE:       r_cfg.max_angle       <= i_cfg.data[LIM_W-1:0];
                REG_SLOW_LOW_ANGLE:  r_cfg.slow_low_angle  <= i_cfg.data[LIM_W-1:0];
                REG_SLOW_HIGH_ANGLE: r_cfg.slow_high_angle <= i_cfg.data[LIM_W-1:0];
                REG_INTEG_ZONE:      r_cfg.integ_zone      <= i_cfg.data[LIM_W-1:0];
                REG_DEAD_BAND:       r_cfg.dead_band       <= i_cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/hpc_loop.sv */
`timescale 1ns / 1ps

module hpc_loop
    import hpc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_commit,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic signed [DATA_W-1:0]  i_target,
    output t_drive_res                o_res
);

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [INTEG_W-1:0] n_integ;

    logic signed [ANGLE_W-1:0] target_ext;
    logic signed [ANGLE_W-1:0] min_s;
    logic signed [ANGLE_W-1:0] max_s;
    logic signed [ANGLE_W-1:0] target_clamped;
    logic                      clamped;
    logic signed [ANGLE_W-1:0] err;
    logic        [ANGLE_W-1:0] mag_w;
    logic        [DATA_W-1:0]  mag;
    logic                      in_zone;
    logic                      in_band;
    logic signed [22:0]        err_x50;
    logic signed [INTEG_W:0]   acc_sum;
    logic signed [INTEG_W-1:0] acc_sat;
    logic signed [INTEG_W-1:0] integ_zoned;
    logic signed [33:0]        p_term;
    logic signed [48:0]        i_term;
    logic signed [50:0]        s_sum;
    logic signed [49:0]        s_half;
    logic signed [DATA_W-1:0]  drive_sat;

    assign target_ext = ANGLE_W'(i_target);
    assign min_s      = $signed({2'b00, i_cfg.min_angle});
    assign max_s      = $signed({2'b00, i_cfg.max_angle});

    // lower clamp wins the test order; with inverted limits a target below min ends at min, any other at max
    always_comb begin
        priority if (target_ext < min_s) begin
            target_clamped = min_s;
            clamped        = 1'b1;
        end else if (target_ext > max_s) begin
            target_clamped = max_s;
            clamped        = 1'b1;
        end else begin
            target_clamped = target_ext;
            clamped        = 1'b0;
        end
    end

    assign err     = i_angle - target_clamped;
    assign mag_w   = err[ANGLE_W-1] ? ANGLE_W'(-err) : ANGLE_W'(err);
    assign mag     = mag_w[DATA_W-1:0];
    assign in_zone = mag < {1'b0, i_cfg.integ_zone};
    assign in_band = mag <= {1'b0, i_cfg.dead_band};

    assign err_x50 = 23'(err) * INTEG_RATE;
    assign acc_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(err_x50);

    always_comb begin
        if (acc_sum[INTEG_W] != acc_sum[INTEG_W-1]) begin
            acc_sat = acc_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[INTEG_W-1:0];
        end
    end

    assign integ_zoned = in_zone ? acc_sat : '0;
    assign n_integ     = in_band ? '0 : integ_zoned;

    assign p_term = 34'($signed({1'b0, i_cfg.prop_gain})) * 34'(err);
    assign i_term = 49'($signed({1'b0, i_cfg.integ_gain})) * 49'(integ_zoned);
    assign s_sum  = -(51'(p_term) + 51'(i_term));
    // floor division by two
    assign s_half = s_sum[50:1];

    always_comb begin
        priority if (s_half > 50'sd32767) begin
            drive_sat = 16'sh7fff;
        end else if (s_half < -50'sd32768) begin
            drive_sat = 16'sh8000;
        end else begin
            drive_sat = s_half[DATA_W-1:0];
        end
    end

    assign o_res.drive     = in_band ? '0 : drive_sat;
    assign o_res.on_target = in_band;
    assign o_res.limited   = clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_commit) begin
            r_integ <= n_integ;
        end
    end

endmodule

/* hw/rtl/hpc_manual.sv */
`timescale 1ns / 1ps

module hpc_manual
    import hpc_pkg::*;
(
    input  t_cfg                      i_cfg,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic signed [DATA_W-1:0]  i_cmd,
    output t_drive_res                o_res
);

    logic signed [DATA_W:0]   cmd_x2;
    logic        [DATA_W:0]   mag_x2;
    logic        [32:0]       prod;
    logic        [14:0]       quot;
    logic signed [DATA_W-1:0] scaled;
    logic                     cmd_neg;
    logic                     cmd_pos;

    assign cmd_x2  = {i_cmd, 1'b0};
    assign cmd_neg = i_cmd[DATA_W-1];
    assign cmd_pos = !cmd_neg && (i_cmd != '0);
    assign mag_x2  = cmd_neg ? (DATA_W+1)'(-cmd_x2) : (DATA_W+1)'(cmd_x2);

    // 0.4x as 2x / 5, truncated toward zero on the magnitude
    assign prod   = 33'(mag_x2) * 33'(DIV5_RECIP);
    assign quot   = prod[32:DIV5_SHIFT];
    assign scaled = cmd_neg ? DATA_W'(-$signed({1'b0, quot})) : DATA_W'(quot);

    always_comb begin
        o_res.on_target = 1'b0;
        priority if (i_angle < $signed({2'b00, i_cfg.min_angle}) && cmd_neg) begin
            o_res.drive   = '0;
            o_res.limited = 1'b1;
        end else if (i_angle < $signed({2'b00, i_cfg.slow_low_angle}) && cmd_neg) begin
            o_res.drive   = scaled;
            o_res.limited = 1'b1;
        end else if (i_angle > $signed({2'b00, i_cfg.max_angle}) && cmd_pos) begin
            o_res.drive   = '0;
            o_res.limited = 1'b1;
        end else if (i_angle > $signed({2'b00, i_cfg.slow_high_angle}) && cmd_pos) begin
            o_res.drive   = scaled;
            o_res.limited = 1'b1;
        end else begin
            o_res.drive   = i_cmd;
            o_res.limited = 1'b0;
        end
    end

endmodule

/* hw/rtl/hood_position_pi_controller_top.sv */
// path: an accepted item goes through the input register and then the result register
// throughput: one transaction per cycle unless the sink stalls, set by the integrator loop
// an input register and a result register part the two sides, so stalls do not lose items
// reset (synchronous, active low) clears both valid flags and the integrator,
// and loads the configuration registers with their default limits
`timescale 1ns / 1ps

module hood_position_pi_controller_top
    import hpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpc_cfg_if.sink    i_cfg,
    hpc_in_if.sink     i_in,
    hpc_out_if.source  o_out
);

    t_cfg       cfg;
    t_drive_res loop_res;
    t_drive_res man_res;
    t_drive_res sel_res;

    logic                      r_in_valid;
    logic                      r_in_op;
    logic signed [DATA_W-1:0]  r_in_encoder;
    logic signed [DATA_W-1:0]  r_in_target;
    logic signed [DATA_W-1:0]  r_in_manual;

    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_drive;
    logic                      r_out_on_target;
    logic                      r_out_limited;

    logic                      advance;
    logic                      commit;
    logic signed [ANGLE_W-1:0] angle;

    hpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign advance    = !r_out_valid || o_out.ready;
    assign commit     = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign angle = ANGLE_OFFSET - ANGLE_W'(r_in_encoder);

    hpc_loop u_loop (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_commit (commit && !r_in_op),
        .i_angle  (angle),
        .i_target (r_in_target),
        .o_res    (loop_res)
    );

    hpc_manual u_manual (
        .i_cfg   (cfg),
        .i_angle (angle),
        .i_cmd   (r_in_manual),
        .o_res   (man_res)
    );

    assign sel_res = r_in_op ? man_res : loop_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op      <= i_in.operation;
            r_in_encoder <= i_in.encoder_reading;
            r_in_target  <= i_in.target_angle;
            r_in_manual  <= i_in.manual_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_drive     <= sel_res.drive;
            r_out_on_target <= sel_res.on_target;
            r_out_limited   <= sel_res.limited;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.drive_command = r_out_drive;
    assign o_out.on_target     = r_out_on_target;
    assign o_out.limited       = r_out_limited;

    // stalling at the input only happens with both stages full and the sink stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without a full pipeline");

    // a committed item always shows up in the result register
    a_commit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed transaction did not reach the output");

    // on target in closed loop gives zero drive at the output
    a_on_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !r_in_op && loop_res.on_target) |=>
            (r_out_on_target && r_out_drive == '0))
        else $error("on-target result with nonzero drive");

    // manual results never report on target
    a_manual_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_in_op) |=> !r_out_on_target)
        else $error("manual transaction flagged on target");

endmodule
